/* src/pcmmix_pkg.sv */
// ----------------------------------------------------------------------------
// pcmmix_pkg
// Types, constants and small arithmetic helpers shared by the two-stream
// pcm mixer modules.
// ----------------------------------------------------------------------------
package pcmmix_pkg;

   localparam int MAX_CHANNELS   = 4;
   localparam int SAMPLE_W       = 32;
   localparam int CFG_W          = 3;
   localparam int CSR_IDX_W      = 3;
   localparam int CH_IDX_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int HEADROOM_SHIFT = 2;
   localparam int MIX_W          = SAMPLE_W - HEADROOM_SHIFT;

   // Q29 clamp limits, held in a full-width signed word
   localparam logic signed [SAMPLE_W-1:0] MIX_HI = (SAMPLE_W'(1) <<< (31 - HEADROOM_SHIFT)) - 1;
   localparam logic signed [SAMPLE_W-1:0] MIX_LO = -(SAMPLE_W'(1) <<< (31 - HEADROOM_SHIFT));

   // register indexes of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PRI_DEPTH = 3'd0,
      CSR_SEC_DEPTH = 3'd1,
      CSR_OUT_DEPTH = 3'd2,
      CSR_PRI_COUNT = 3'd3,
      CSR_SEC_COUNT = 3'd4,
      CSR_OUT_COUNT = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [CFG_W-1:0] primary_depth;
      logic [CFG_W-1:0] secondary_depth;
      logic [CFG_W-1:0] output_depth;
      logic [CFG_W-1:0] primary_count;
      logic [CFG_W-1:0] secondary_count;
      logic [CFG_W-1:0] output_count;
   } cfg_type;

   // depth must be 1 to 4 bytes
   function automatic logic depth_ok(logic [CFG_W-1:0] depth);
      return (depth >= CFG_W'(1)) && (depth <= CFG_W'(4));
   endfunction

   // channel count limited to the lanes that exist
   function automatic logic [CFG_W-1:0] clamp_count(logic [CFG_W-1:0] count);
      return (count > CFG_W'(MAX_CHANNELS)) ? CFG_W'(MAX_CHANNELS) : count;
   endfunction

   // source channel for an output lane: same number, or the last one present
   function automatic logic [CH_IDX_W-1:0] src_index(logic [CH_IDX_W-1:0] ch,
                                                     logic [CFG_W-1:0] count);
      logic [CFG_W-1:0] cnt;
      logic [CFG_W-1:0] last;
      cnt  = clamp_count(count);
      last = cnt - CFG_W'(1);
      return (CFG_W'(ch) < cnt) ? ch : last[CH_IDX_W-1:0];
   endfunction

   // low depth bytes moved to the top of a q31 word
   function automatic logic signed [SAMPLE_W-1:0] align_q31(logic [SAMPLE_W-1:0] raw,
                                                            logic [CFG_W-1:0] depth);
      logic signed [SAMPLE_W-1:0] res;
      case (depth)
         3'd1:    res = {raw[7:0], 24'b0};
         3'd2:    res = {raw[15:0], 16'b0};
         3'd3:    res = {raw[23:0], 8'b0};
         default: res = raw;
      endcase
      return res;
   endfunction

   // half an output lsb, seen after the mix shift
   function automatic logic signed [SAMPLE_W-1:0] half_lsb(logic [CFG_W-1:0] depth);
      logic signed [SAMPLE_W-1:0] res;
      case (depth)
         3'd1:    res = SAMPLE_W'(1) <<< (24 - HEADROOM_SHIFT - 1);
         3'd2:    res = SAMPLE_W'(1) <<< (16 - HEADROOM_SHIFT - 1);
         3'd3:    res = SAMPLE_W'(1) <<< (8 - HEADROOM_SHIFT - 1);
         default: res = '0;
      endcase
      return res;
   endfunction

   // arithmetic shift down to the output depth
   function automatic logic [SAMPLE_W-1:0] depth_trunc(logic [SAMPLE_W-1:0] q,
                                                      logic [CFG_W-1:0] depth);
      logic [SAMPLE_W-1:0] res;
      case (depth)
         3'd1:    res = {{24{q[SAMPLE_W-1]}}, q[SAMPLE_W-1:24]};
         3'd2:    res = {{16{q[SAMPLE_W-1]}}, q[SAMPLE_W-1:16]};
         3'd3:    res = {{8{q[SAMPLE_W-1]}}, q[SAMPLE_W-1:8]};
         default: res = q;
      endcase
      return res;
   endfunction

endpackage

/* src/pcmmix_if.sv */
// ----------------------------------------------------------------------------
// pcmmix interfaces
// Valid/ready channels for input frames, mixed frames and register writes.
// ----------------------------------------------------------------------------
interface pcmmix_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] pri_s0;
   logic [31:0] pri_s1;
   logic [31:0] pri_s2;
   logic [31:0] pri_s3;
   logic [31:0] sec_s0;
   logic [31:0] sec_s1;
   logic [31:0] sec_s2;
   logic [31:0] sec_s3;
   logic        end_of_block;

   modport source (output valid, pri_s0, pri_s1, pri_s2, pri_s3,
                   sec_s0, sec_s1, sec_s2, sec_s3, end_of_block, input ready);
   modport sink (input valid, pri_s0, pri_s1, pri_s2, pri_s3,
                 sec_s0, sec_s1, sec_s2, sec_s3, end_of_block, output ready);
endinterface

interface pcmmix_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] mix_s0;
   logic [31:0] mix_s1;
   logic [31:0] mix_s2;
   logic [31:0] mix_s3;
   logic        block_end;

   modport source (output valid, mix_s0, mix_s1, mix_s2, mix_s3, block_end, input ready);
   modport sink (input valid, mix_s0, mix_s1, mix_s2, mix_s3, block_end, output ready);
endinterface

interface pcmmix_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] index;
   logic [2:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* src/pcmmix_csr.sv */
// ----------------------------------------------------------------------------
// pcmmix_csr
// Configuration registers of the mixer and the check that the setup can mix.
// ----------------------------------------------------------------------------
module pcmmix_csr (
   input  logic               clock,
   input  logic               reset,
   pcmmix_csr_if.sink         csr_bus,
   output pcmmix_pkg::cfg_type cfg,
   output logic               cfg_ok
);
   import pcmmix_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // writes are always taken
   assign csr_bus.ready = 1'b1;

   // register write decode, unknown indexes ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_PRI_DEPTH: cfg_in.primary_depth   = csr_bus.data;
            CSR_SEC_DEPTH: cfg_in.secondary_depth = csr_bus.data;
            CSR_OUT_DEPTH: cfg_in.output_depth    = csr_bus.data;
            CSR_PRI_COUNT: cfg_in.primary_count   = csr_bus.data;
            CSR_SEC_COUNT: cfg_in.secondary_count = csr_bus.data;
            CSR_OUT_COUNT: cfg_in.output_count    = csr_bus.data;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{primary_depth: 3'd2, secondary_depth: 3'd2, output_depth: 3'd2,
                     primary_count: 3'd2, secondary_count: 3'd2, output_count: 3'd2};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // frames are mixed only with legal depths and nonzero counts
   assign cfg     = cfg_ff;
   assign cfg_ok  = depth_ok(cfg_ff.primary_depth) && depth_ok(cfg_ff.secondary_depth) &&
                    depth_ok(cfg_ff.output_depth) &&
                    (cfg_ff.primary_count != '0) && (cfg_ff.secondary_count != '0) &&
                    (cfg_ff.output_count != '0);

endmodule

/* src/pcmmix_lane.sv */
// ----------------------------------------------------------------------------
// pcmmix_lane
// Mixes one primary and one secondary sample: align, scale, add with
// rounding, clamp to q29 and cut down to the output depth.
// ----------------------------------------------------------------------------
module pcmmix_lane (
   input  logic [31:0]                   pri_sample,
   input  logic [31:0]                   sec_sample,
   input  logic [pcmmix_pkg::CFG_W-1:0]  pri_depth,
   input  logic [pcmmix_pkg::CFG_W-1:0]  sec_depth,
   input  logic [pcmmix_pkg::CFG_W-1:0]  out_depth,
   output logic [31:0]                   mix
);
   import pcmmix_pkg::*;

   logic signed [SAMPLE_W-1:0] pri_al;
   logic signed [SAMPLE_W-1:0] sec_al;
   logic signed [SAMPLE_W-1:0] sum;
   logic        [MIX_W-1:0]    clamped;
   logic        [SAMPLE_W-1:0] scaled;

   // q31 alignment and the mix headroom shift
   assign pri_al = align_q31(pri_sample, pri_depth);
   assign sec_al = align_q31(sec_sample, sec_depth);
   assign sum    = {{HEADROOM_SHIFT{pri_al[SAMPLE_W-1]}}, pri_al[SAMPLE_W-1:HEADROOM_SHIFT]}
                 + {{HEADROOM_SHIFT{sec_al[SAMPLE_W-1]}}, sec_al[SAMPLE_W-1:HEADROOM_SHIFT]}
                 + half_lsb(out_depth);

   // saturate to q29
   always_comb begin
      if (sum > MIX_HI) begin
         clamped = MIX_HI[MIX_W-1:0];
      end else if (sum < MIX_LO) begin
         clamped = MIX_LO[MIX_W-1:0];
      end else begin
         clamped = sum[MIX_W-1:0];
      end
   end

   // undo the headroom shift and truncate to the output depth
   assign scaled = {clamped, {HEADROOM_SHIFT{1'b0}}};
   assign mix    = depth_trunc(scaled, out_depth);

endmodule

/* src/two_stream_pcm_mixer.sv */
// ----------------------------------------------------------------------------
// two_stream_pcm_mixer
// Path: an accepted frame goes into the input register, then its mixed frame
// into the result register that drives rsp_bus. Throughput: one frame per
// cycle while rsp_bus does not stall; the input and result registers let a new
// frame enter while the previous result waits for rsp_bus.ready. Reset:
// synchronous, active high; empties both stages and sets every depth and
// count register to 2. Frames taken with an illegal setup give no result.
// ----------------------------------------------------------------------------
module two_stream_pcm_mixer (
   input  logic         clock,
   input  logic         reset,
   pcmmix_req_if.sink   req_bus,
   pcmmix_rsp_if.source rsp_bus,
   pcmmix_csr_if.sink   csr_bus
);
   import pcmmix_pkg::*;

   cfg_type           cfg;
   logic              cfg_ok;
   logic [CFG_W-1:0]  out_cnt;

   logic              in_valid_ff;
   logic              in_valid_in;
   logic [31:0]       in_pri_ff [MAX_CHANNELS];
   logic [31:0]       in_sec_ff [MAX_CHANNELS];
   logic              in_eob_ff;

   logic              out_valid_ff;
   logic              out_valid_in;
   logic [31:0]       out_mix_ff [MAX_CHANNELS];
   logic [31:0]       out_mix_in [MAX_CHANNELS];
   logic              out_eob_ff;

   logic              advance;
   logic              req_take;

   pcmmix_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg),
      .cfg_ok  (cfg_ok)
   );

   // handshake: the input stage moves on whenever the result register is empty or being taken by rsp_bus
   assign advance       = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_take      = req_bus.valid && req_bus.ready;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (advance) begin
         out_valid_in = in_valid_ff && cfg_ok;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_pri_ff[0] <= req_bus.pri_s0;
         in_pri_ff[1] <= req_bus.pri_s1;
         in_pri_ff[2] <= req_bus.pri_s2;
         in_pri_ff[3] <= req_bus.pri_s3;
         in_sec_ff[0] <= req_bus.sec_s0;
         in_sec_ff[1] <= req_bus.sec_s1;
         in_sec_ff[2] <= req_bus.sec_s2;
         in_sec_ff[3] <= req_bus.sec_s3;
         in_eob_ff    <= req_bus.end_of_block;
      end
   end

   // mixing lanes, one per output channel
   assign out_cnt = clamp_count(cfg.output_count);

   for (genvar ch = 0; ch < MAX_CHANNELS; ch++) begin : g_lane
      logic [CH_IDX_W-1:0] pri_idx;
      logic [CH_IDX_W-1:0] sec_idx;
      logic [31:0]         lane_mix;

      assign pri_idx = src_index(CH_IDX_W'(ch), cfg.primary_count);
      assign sec_idx = src_index(CH_IDX_W'(ch), cfg.secondary_count);

      pcmmix_lane u_lane (
         .pri_sample (in_pri_ff[pri_idx]),
         .sec_sample (in_sec_ff[sec_idx]),
         .pri_depth  (cfg.primary_depth),
         .sec_depth  (cfg.secondary_depth),
         .out_depth  (cfg.output_depth),
         .mix        (lane_mix)
      );

      // lanes past the output count stay silent
      assign out_mix_in[ch] = (CFG_W'(ch) < out_cnt) ? lane_mix : '0;
   end

   // result register
   always_ff @(posedge clock) begin
      if (advance && in_valid_ff) begin
         out_mix_ff <= out_mix_in;
         out_eob_ff <= in_eob_ff;
      end
   end

   assign rsp_bus.valid     = out_valid_ff;
   assign rsp_bus.mix_s0    = out_mix_ff[0];
   assign rsp_bus.mix_s1    = out_mix_ff[1];
   assign rsp_bus.mix_s2    = out_mix_ff[2];
   assign rsp_bus.mix_s3    = out_mix_ff[3];
   assign rsp_bus.block_end = out_eob_ff;

   // a new result only comes from a held frame and a legal setup
   a_rise_from_frame: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(in_valid_ff) && $past(cfg_ok))
      else $error("result appeared without a frame or with an illegal setup");

   // a held frame that cannot move blocks the input
   a_hold_blocks_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && !rsp_bus.ready |-> !req_bus.ready)
      else $error("input accepted while the input stage is stuck");

   // a frame is never lost while the result register is full and stalled
   a_frame_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff)
      else $error("stalled frame dropped");

   // silent lane when the output count is one
   a_silent_lane: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) && ($past(cfg.output_count) == 3'd1) |-> rsp_bus.mix_s1 == '0)
      else $error("unused output lane not zero");

endmodule
